/* rtl/salc_pkg.sv */
// Shared types and defaults for the set-associative LRU byte cache.
// Used by salc_ctrl, salc_dp and set_assoc_lru_byte_cache_top.
`timescale 1ns / 1ps
package salc_pkg;

    localparam int DEF_NUM_WAYS     = 8;
    localparam int DEF_NUM_SETS     = 32;
    localparam int DEF_BLOCK_BYTES  = 64;
    localparam int DEF_ADDRESS_BITS = 16;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_LOAD,
        CMD_SCAN_RD,
        CMD_SCAN_CHK,
        CMD_DECIDE,
        CMD_WB,
        CMD_FILL,
        CMD_UPDATE,
        CMD_RESP
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic scan_stop;
        logic found;
        logic victim_valid;
        logic copy_done;
        logic out_free;
    } status_t;

endpackage

/* rtl/salc_ctrl.sv */
// Controller state machine of the byte cache.
// Depends on salc_pkg for the command and status types.
`timescale 1ns / 1ps
module salc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  salc_pkg::status_t status,
    output salc_pkg::cmd_t    cmd
);
    import salc_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_DECIDE,
        ST_WB,
        ST_FILL,
        ST_UPDATE,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd = CMD_CLEAR;
                if (status.clear_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd        = CMD_LOAD;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                cmd        = CMD_SCAN_RD;
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                cmd        = CMD_SCAN_CHK;
                state_next = status.scan_stop ? ST_DECIDE : ST_SCAN_RD;
            end
            ST_DECIDE: begin
                cmd = CMD_DECIDE;
                priority if (status.found)        state_next = ST_UPDATE;
                else if (status.victim_valid)     state_next = ST_WB;
                else                              state_next = ST_FILL;
            end
            ST_WB: begin
                cmd = CMD_WB;
                if (status.copy_done) state_next = ST_FILL;
            end
            ST_FILL: begin
                cmd = CMD_FILL;
                if (status.copy_done) state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd        = CMD_UPDATE;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (status.out_free) begin
                    cmd        = CMD_RESP;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    a_accept_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted twice in a row");
    a_no_ready_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == CMD_CLEAR) |-> !s_ready)
        else $error("ready during clearing pass");
    a_resp_then_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == CMD_RESP) |=> s_ready)
        else $error("not idle after response");

endmodule

/* rtl/salc_dp.sv */
// Datapath of the byte cache: request registers, tag/stamp store, valid bits,
// line and main memories, counters and output register. Depends on salc_pkg.
`timescale 1ns / 1ps
module salc_dp #(
    parameter int NUM_WAYS     = salc_pkg::DEF_NUM_WAYS,
    parameter int NUM_SETS     = salc_pkg::DEF_NUM_SETS,
    parameter int BLOCK_BYTES  = salc_pkg::DEF_BLOCK_BYTES,
    parameter int ADDRESS_BITS = salc_pkg::DEF_ADDRESS_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  salc_pkg::cmd_t          cmd,
    output salc_pkg::status_t       status,
    input  logic                    s_mode,
    input  logic [ADDRESS_BITS-1:0] s_address,
    input  logic [7:0]              s_write_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [7:0]              m_read_data,
    output logic                    m_hit,
    output logic [31:0]             m_access_count,
    output logic [31:0]             m_miss_count
);
    import salc_pkg::*;

    localparam int LINES   = NUM_WAYS * NUM_SETS;
    localparam int LINE_W  = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int OFF_W   = $clog2(BLOCK_BYTES);
    localparam int TAG_RAW = ADDRESS_BITS - OFF_W - $clog2(NUM_SETS);
    localparam int TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int LB_W    = $clog2(LINES * BLOCK_BYTES);
    localparam int LB_DEPTH  = LINES * BLOCK_BYTES;
    localparam int MEM_DEPTH = 1 << ADDRESS_BITS;
    localparam int CNT_W   = OFF_W + 1;

    function automatic logic [LINE_W-1:0] line_of(input logic [WAY_W-1:0] w,
                                                  input logic [SET_W-1:0] s);
        return LINE_W'(int'(w) * NUM_SETS + int'(s));
    endfunction

    logic                    mode_reg;
    logic [ADDRESS_BITS-1:0] addr_reg;
    logic [7:0]              wdata_reg;
    logic [WAY_W-1:0]        way_reg, hit_way_reg, inv_way_reg, min_way_reg;
    logic                    found_reg, inv_any_reg;
    logic [31:0]             min_stamp_reg;
    logic [TAG_W-1:0]        min_tag_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [ADDRESS_BITS-1:0] clr_reg;
    logic [31:0]             clock_reg, acc_reg, miss_reg;
    logic [LINES-1:0]        valid_reg;

    logic [TAG_W-1:0] tag_mem [LINES];
    logic [31:0]      stamp_mem [LINES];
    logic [7:0]       line_mem [LB_DEPTH];
    logic [7:0]       main_mem [MEM_DEPTH];
    logic [TAG_W-1:0] tag_rd_reg;
    logic [31:0]      stamp_rd_reg;
    logic [7:0]       line_rd_reg, main_rd_reg;

    logic                    m_valid_reg, m_hit_reg;
    logic [7:0]              m_data_reg;
    logic [31:0]             m_acc_reg, m_miss_reg;

    logic [OFF_W-1:0]        off;
    logic [SET_W-1:0]        set_idx;
    logic [TAG_W-1:0]        tag_val;
    logic [WAY_W-1:0]        ln_way;
    logic [LINE_W-1:0]       scan_line, ln_cur;
    logic [CNT_W-1:0]        cnt_m1;
    logic [LB_W-1:0]         lb_rd, lb_wr, lb_off;
    logic [ADDRESS_BITS-1:0] fill_addr, wb_addr;
    logic                    match_now, copy_rd, copy_wr;

    assign off       = addr_reg[OFF_W-1:0];
    assign set_idx   = SET_W'((addr_reg >> OFF_W) % NUM_SETS);
    assign tag_val   = TAG_W'((addr_reg >> OFF_W) / NUM_SETS);
    assign ln_way    = found_reg ? hit_way_reg : (inv_any_reg ? inv_way_reg : min_way_reg);
    assign scan_line = line_of(way_reg, set_idx);
    assign ln_cur    = line_of(ln_way, set_idx);
    assign cnt_m1    = cnt_reg - CNT_W'(1);
    assign lb_rd     = LB_W'(int'(ln_cur) * BLOCK_BYTES + int'(cnt_reg[OFF_W-1:0]));
    assign lb_wr     = LB_W'(int'(ln_cur) * BLOCK_BYTES + int'(cnt_m1[OFF_W-1:0]));
    assign lb_off    = LB_W'(int'(ln_cur) * BLOCK_BYTES + int'(off));
    assign fill_addr = ADDRESS_BITS'((addr_reg >> OFF_W) * BLOCK_BYTES
                                     + int'(cnt_reg[OFF_W-1:0]));
    assign wb_addr   = ADDRESS_BITS'((int'(min_tag_reg) * NUM_SETS + int'(set_idx))
                                     * BLOCK_BYTES + int'(cnt_m1[OFF_W-1:0]));
    assign match_now = valid_reg[scan_line] && (tag_rd_reg == tag_val);
    assign copy_rd   = (cnt_reg != CNT_W'(BLOCK_BYTES));
    assign copy_wr   = (cnt_reg != '0);

    assign status.clear_done   = (clr_reg == '1);
    assign status.scan_stop    = match_now || (way_reg == WAY_W'(NUM_WAYS - 1));
    assign status.found        = found_reg;
    assign status.victim_valid = !inv_any_reg;
    assign status.copy_done    = (cnt_reg == CNT_W'(BLOCK_BYTES));
    assign status.out_free     = !m_valid_reg || m_ready;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= '0;
            cnt_reg     <= '0;
            way_reg     <= '0;
            found_reg   <= 1'b0;
            inv_any_reg <= 1'b0;
            clock_reg   <= '0;
            acc_reg     <= '0;
            miss_reg    <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd == CMD_RESP) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (cmd)
                CMD_CLEAR: clr_reg <= clr_reg + 1'b1;
                CMD_LOAD: begin
                    way_reg     <= '0;
                    found_reg   <= 1'b0;
                    inv_any_reg <= 1'b0;
                    cnt_reg     <= '0;
                end
                CMD_SCAN_CHK: begin
                    if (match_now) found_reg <= 1'b1;
                    if (!valid_reg[scan_line]) inv_any_reg <= 1'b1;
                    way_reg <= way_reg + 1'b1;
                end
                CMD_DECIDE: cnt_reg <= '0;
                CMD_WB, CMD_FILL: begin
                    cnt_reg <= copy_rd ? cnt_reg + 1'b1 : '0;
                end
                CMD_UPDATE: begin
                    valid_reg[ln_cur] <= 1'b1;
                    clock_reg <= clock_reg + 1'b1;
                    acc_reg   <= acc_reg + 1'b1;
                    miss_reg  <= miss_reg + {31'd0, !found_reg};
                end
                default: ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd == CMD_LOAD) begin
            mode_reg  <= s_mode;
            addr_reg  <= s_address;
            wdata_reg <= s_write_data;
        end
        if (cmd == CMD_SCAN_CHK) begin
            if (match_now) hit_way_reg <= way_reg;
            if (!valid_reg[scan_line]) inv_way_reg <= way_reg;
            if (way_reg == '0 || stamp_rd_reg < min_stamp_reg) begin
                min_stamp_reg <= stamp_rd_reg;
                min_way_reg   <= way_reg;
                min_tag_reg   <= tag_rd_reg;
            end
        end
        if (cmd == CMD_RESP) begin
            m_data_reg <= mode_reg ? wdata_reg : line_rd_reg;
            m_hit_reg  <= found_reg;
            m_acc_reg  <= acc_reg;
            m_miss_reg <= miss_reg;
        end
    end

    // Tag and stamp store.
    always_ff @(posedge aclk) begin
        if (cmd == CMD_SCAN_RD) begin
            tag_rd_reg   <= tag_mem[scan_line];
            stamp_rd_reg <= stamp_mem[scan_line];
        end
        if (cmd == CMD_UPDATE) begin
            tag_mem[ln_cur]   <= tag_val;
            stamp_mem[ln_cur] <= clock_reg;
        end
    end

    // Line memory.
    always_ff @(posedge aclk) begin
        if (cmd == CMD_FILL && copy_wr) begin
            line_mem[lb_wr] <= main_rd_reg;
        end else if (cmd == CMD_UPDATE && mode_reg) begin
            line_mem[lb_off] <= wdata_reg;
        end
        if (cmd == CMD_WB && copy_rd) begin
            line_rd_reg <= line_mem[lb_rd];
        end else if (cmd == CMD_UPDATE) begin
            line_rd_reg <= line_mem[lb_off];
        end
    end

    // Main memory.
    always_ff @(posedge aclk) begin
        if (cmd == CMD_CLEAR) begin
            main_mem[clr_reg] <= 8'd0;
        end else if (cmd == CMD_WB && copy_wr) begin
            main_mem[wb_addr] <= line_rd_reg;
        end
        if (cmd == CMD_FILL && copy_rd) begin
            main_rd_reg <= main_mem[fill_addr];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_read_data    = m_data_reg;
    assign m_hit          = m_hit_reg;
    assign m_access_count = m_acc_reg;
    assign m_miss_count   = m_miss_reg;

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(BLOCK_BYTES))
        else $error("copy counter out of range");
    a_hit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == CMD_UPDATE && found_reg) |-> valid_reg[ln_cur])
        else $error("hit on an invalid line");
    a_resp_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == CMD_RESP) |=> m_valid_reg)
        else $error("result not presented");

endmodule

/* rtl/set_assoc_lru_byte_cache_top.sv */
// Top level of the set-associative LRU write-back byte cache.
// Each request runs a way-serial tag scan; a miss adds byte-wide block copies.
// Throughput: one request at a time; the next is taken in the cycle after its result is loaded.
// Reset: synchronous active-low; afterwards a clearing pass zeroes all of main memory
//   and no request is accepted until it ends.
`timescale 1ns / 1ps
module set_assoc_lru_byte_cache_top #(
    parameter int NUM_WAYS     = salc_pkg::DEF_NUM_WAYS,
    parameter int NUM_SETS     = salc_pkg::DEF_NUM_SETS,
    parameter int BLOCK_BYTES  = salc_pkg::DEF_BLOCK_BYTES,
    parameter int ADDRESS_BITS = salc_pkg::DEF_ADDRESS_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_mode,
    input  logic [ADDRESS_BITS-1:0] s_address,
    input  logic [7:0]              s_write_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [7:0]              m_read_data,
    output logic                    m_hit,
    output logic [31:0]             m_access_count,
    output logic [31:0]             m_miss_count
);
    import salc_pkg::*;

    // Command from the controller, status back from the datapath.
    cmd_t    cmd;
    status_t status;

    // Sequence each request: scan ways, on a miss write back a valid victim and
    // fill the block, update the line, then hand the result to the output register.
    salc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Hold all storage; the output register lets a result wait while the next request runs.
    salc_dp #(
        .NUM_WAYS     (NUM_WAYS),
        .NUM_SETS     (NUM_SETS),
        .BLOCK_BYTES  (BLOCK_BYTES),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_mode         (s_mode),
        .s_address      (s_address),
        .s_write_data   (s_write_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_data    (m_read_data),
        .m_hit          (m_hit),
        .m_access_count (m_access_count),
        .m_miss_count   (m_miss_count)
    );

endmodule
